// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sorted key set block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SKS_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the module's clk_i / rst_ni.
`define SKS_ASSERT(lbl, prop, msg) `SKS_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key set package
// Operation and status codes, controller/datapath command and status types.
// ----------------------------------------------------------------------------
package sks_pkg;

  localparam int unsigned DefaultCapacity = 64;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_NTH    = 3'd3;
  localparam logic [2:0] OP_FIRST  = 3'd4;
  localparam logic [2:0] OP_LAST   = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Walk pointer update
  typedef enum logic [2:0] {
    I_HOLD,
    I_ZERO,
    I_INC,
    I_DEC,
    I_COUNT,
    I_NTH,
    I_LAST
  } iop_e;

  // Read address relative to the walk pointer
  typedef enum logic [1:0] {
    RD_I,
    RD_IM1,
    RD_IP1
  } rsel_e;

  // Key count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cop_e;

  typedef struct packed {
    logic       latch;
    iop_e       i_op;
    logic       slot_ld;
    logic       slot_hit;
    logic       rd_en;
    rsel_e      rd_sel;
    logic       wr_en;
    logic       wr_key;
    cop_e       cnt_op;
    logic       out_ld;
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       lt;
    logic       eq;
    logic       scan_end;
    logic       hit;
    logic       full;
    logic       nth_bad;
    logic       empty;
    logic       ins_done;
    logic       del_done;
  } sts_t;

endpackage

// ===== hdl/sks_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sks_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted key set controller
// Sequences scan, shift and read steps and owns the result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sks_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sks_pkg::sts_t sts_i,
  output sks_pkg::cmd_t cmd_o
);

  import sks_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_INS_CHK  = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_DEL_CHK  = 4'd7;
  localparam logic [3:0] S_DEL_WR   = 4'd8;
  localparam logic [3:0] S_READ     = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  cmd_t       cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd            = '0;
    cmd.i_op       = I_HOLD;
    cmd.rd_sel     = RD_I;
    cmd.cnt_op     = CNT_HOLD;
    cmd.out_status = res_q;
    state_d        = state_q;
    res_d          = res_q;
    case (state_q)
      S_IDLE: begin
        cmd.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d   = ST_REJECTED;
        state_d = S_DONE;
        case (sts_i.op)
          OP_INSERT, OP_DELETE, OP_SEARCH: begin
            cmd.i_op = I_ZERO;
            state_d  = S_SCAN_CHK;
          end
          OP_NTH: begin
            if (!sts_i.nth_bad) begin
              cmd.i_op = I_NTH;
              state_d  = S_READ;
            end
          end
          OP_FIRST: begin
            if (!sts_i.empty) begin
              cmd.i_op = I_ZERO;
              state_d  = S_READ;
            end
          end
          OP_LAST: begin
            if (!sts_i.empty) begin
              cmd.i_op = I_LAST;
              state_d  = S_READ;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
            res_d      = ST_DONE;
          end
          default: begin
            res_d = ST_REJECTED;
          end
        endcase
      end
      S_SCAN_CHK: begin
        if (sts_i.scan_end) begin
          cmd.slot_ld = 1'b1;
          state_d     = S_DECIDE;
        end else begin
          cmd.rd_en = 1'b1;
          state_d   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.lt) begin
          cmd.i_op = I_INC;
          state_d  = S_SCAN_CHK;
        end else begin
          cmd.slot_ld  = 1'b1;
          cmd.slot_hit = sts_i.eq;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_d   = ST_REJECTED;
        state_d = S_DONE;
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.hit) begin
              res_d = ST_REJECTED;
            end else if (sts_i.full) begin
              res_d = ST_FULL;
            end else begin
              cmd.i_op = I_COUNT;
              state_d  = S_INS_CHK;
            end
          end
          OP_DELETE: begin
            if (sts_i.hit) begin
              state_d = S_DEL_CHK;
            end
          end
          default: begin
            res_d = sts_i.hit ? ST_DONE : ST_REJECTED;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ins_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_key = 1'b1;
          cmd.cnt_op = CNT_INC;
          res_d      = ST_DONE;
          state_d    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IM1;
          state_d    = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en = 1'b1;
        cmd.i_op  = I_DEC;
        state_d   = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.del_done) begin
          cmd.cnt_op = CNT_DEC;
          res_d      = ST_DONE;
          state_d    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IP1;
          state_d    = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en = 1'b1;
        cmd.i_op  = I_INC;
        state_d   = S_DEL_CHK;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        res_d     = ST_DONE;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // read data stays put here since no read is issued
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `SKS_ASSERT(a_accept_dispatch, (in_valid_i && in_ready_o) |=> (state_q == S_DISPATCH), "accepted beat not dispatched")
  `SKS_ASSERT(a_load_free, (state_q == S_DONE && out_free) |=> out_valid_q, "result beat not presented")

endmodule

// ===== hdl/sks_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted key set datapath
// Key store, walk pointer, key count, compare and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sks_dp #(
  parameter int unsigned CAPACITY = sks_pkg::DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sks_pkg::cmd_t      cmd_i,
  output sks_pkg::sts_t      sts_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] key_i,
  input  logic [6:0]         index_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_o,
  output logic [6:0]         position_o,
  output logic [6:0]         count_o
);

  import sks_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = (CW > 7) ? CW : 7;

  logic [2:0]         op_q;
  logic signed [31:0] key_q;
  logic [6:0]         idx_q;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      slot_q;
  logic               hit_q;
  logic [CW-1:0]      count_q, count_d;

  logic [1:0]         status_q;
  logic signed [31:0] value_q;
  logic [6:0]         position_q;
  logic [6:0]         count_out_q;

  logic [CW-1:0]      rd_ptr;
  logic [31:0]        rdata;
  logic signed [31:0] rkey;
  logic [NW-1:0]      idx_m1;
  logic [CW:0]        i_p1_w;
  logic [CW+7:0]      pos_w;
  logic [CW+7:0]      cnt_w;
  logic signed [31:0] value_d;
  logic [6:0]         position_d;

  assign rkey   = $signed(rdata);
  assign idx_m1 = NW'(idx_q) - NW'(1);
  assign i_p1_w = (CW + 1)'(i_q) + (CW + 1)'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IM1:  rd_ptr = i_q - CW'(1);
      RD_IP1:  rd_ptr = i_q + CW'(1);
      default: rd_ptr = i_q;
    endcase
  end

  sks_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(i_q[AW-1:0]),
    .wdata_i(cmd_i.wr_key ? key_q : rdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_ptr[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    case (cmd_i.i_op)
      I_ZERO:  i_d = '0;
      I_INC:   i_d = i_q + CW'(1);
      I_DEC:   i_d = i_q - CW'(1);
      I_COUNT: i_d = count_q;
      I_NTH:   i_d = idx_m1[CW-1:0];
      I_LAST:  i_d = count_q - CW'(1);
      default: i_d = i_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_q - CW'(1);
      CNT_CLR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  // Result fields are shaped from the finished operation
  assign pos_w = (CW + 8)'(slot_q) + (CW + 8)'(1);
  assign cnt_w = (CW + 8)'(count_q);

  always_comb begin
    value_d    = '0;
    position_d = '0;
    if (cmd_i.out_status == ST_DONE) begin
      if (op_q inside {OP_NTH, OP_FIRST, OP_LAST}) begin
        value_d = rkey;
      end
      if (op_q == OP_SEARCH) begin
        position_d = pos_w[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      key_q <= key_i;
      idx_q <= index_i;
    end
    i_q <= i_d;
    if (cmd_i.slot_ld) begin
      slot_q <= i_q;
      hit_q  <= cmd_i.slot_hit;
    end
    if (cmd_i.out_ld) begin
      status_q    <= cmd_i.out_status;
      value_q     <= value_d;
      position_q  <= position_d;
      count_out_q <= cnt_w[6:0];
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.lt       = rkey < key_q;
    sts_o.eq       = rkey == key_q;
    sts_o.scan_end = i_q == count_q;
    sts_o.hit      = hit_q;
    sts_o.full     = count_q >= CW'(CAPACITY);
    sts_o.nth_bad  = (idx_q == '0) || (NW'(idx_q) > NW'(count_q));
    sts_o.empty    = count_q == '0;
    sts_o.ins_done = i_q == slot_q;
    sts_o.del_done = i_p1_w == (CW + 1)'(count_q);
  end

  assign status_o   = status_q;
  assign value_o    = value_q;
  assign position_o = position_q;
  assign count_o    = count_out_q;

  `SKS_ASSERT(a_count_cap, count_q <= CW'(CAPACITY), "key count above capacity")
  `SKS_ASSERT(a_ins_room, (cmd_i.wr_en && cmd_i.wr_key) |-> (count_q < CW'(CAPACITY)), "insert into full store")
  `SKS_ASSERT(a_del_hit, (cmd_i.cnt_op == CNT_DEC) |-> (hit_q && (count_q != '0)), "delete without a hit")

endmodule

// ===== hdl/sorted_unique_key_set.sv =====
// ----------------------------------------------------------------------------
// Sorted unique key set
// Ordered set of distinct signed keys with insert, delete, search and reads.
// ----------------------------------------------------------------------------
// Keys live in one RAM in ascending order and are handled one request at a
// time. Search, insert and delete walk the store from the bottom, reading
// and then comparing each key below the requested one; insert then moves
// every larger key up one slot and delete moves every larger key down, each
// move a read and then a write. Nth, first and last pass through dispatch, a
// read and done; clear, an unused code and a rejected nth, first or last go
// from dispatch to done. A rejected search, insert or delete still walks the
// store first. Each step is paced by the single RAM read port's registered data.
// A new request is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module sorted_unique_key_set #(
  parameter int unsigned CAPACITY = sks_pkg::DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] key_i,
  input  logic [6:0]         index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_o,
  output logic [6:0]         position_o,
  output logic [6:0]         count_o
);

  import sks_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sks_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .operation_i(operation_i),
    .key_i      (key_i),
    .index_i    (index_i),
    .status_o   (status_o),
    .value_o    (value_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted unique key set testbench
// Drives insert, delete, search, nth, first, last and clear requests into the
// key set, keeps a shadow copy of the ordered keys to predict every result,
// and checks each result beat field by field, with and without random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import sks_pkg::*;

  localparam int unsigned KeyCap = sks_pkg::DefaultCapacity;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned DrainCycles = 300;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [6:0]         position;
    logic [6:0]         count;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         operation_i;
  logic signed [31:0] key_i;
  logic [6:0]         index_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] value_o;
  logic [6:0]         position_o;
  logic [6:0]         count_o;

  // Shadow of the key store and the results still owed by the block
  logic signed [31:0] shadow_keys [KeyCap];
  int unsigned        shadow_count;
  result_t            pending_results [$];

  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  int unsigned error_count;

  sorted_unique_key_set #(
    .CAPACITY(KeyCap)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .key_i      (key_i),
    .index_i    (index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .value_o    (value_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Applies one request to the shadow set and returns the result it owes
  function automatic result_t apply_to_key_set(logic [2:0] op, logic signed [31:0] key,
                                               logic [6:0] idx);
    result_t     res;
    int unsigned slot;
    bit          hit;
    res.status   = ST_DONE;
    res.value    = '0;
    res.position = '0;
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] < key) slot++;
    hit = (slot < shadow_count) && (shadow_keys[slot] == key);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          res.status = ST_REJECTED;
        end else if (shadow_count >= KeyCap) begin
          res.status = ST_FULL;
        end else begin
          for (int unsigned j = shadow_count; j > slot; j--) shadow_keys[j] = shadow_keys[j-1];
          shadow_keys[slot] = key;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (!hit) begin
          res.status = ST_REJECTED;
        end else begin
          for (int unsigned j = slot; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        if (hit) res.position = 7'(slot + 1);
        else res.status = ST_REJECTED;
      end
      OP_NTH: begin
        if (idx == 0 || idx > shadow_count) res.status = ST_REJECTED;
        else res.value = shadow_keys[idx-1];
      end
      OP_FIRST: begin
        if (shadow_count == 0) res.status = ST_REJECTED;
        else res.value = shadow_keys[0];
      end
      OP_LAST: begin
        if (shadow_count == 0) res.status = ST_REJECTED;
        else res.value = shadow_keys[shadow_count-1];
      end
      OP_CLEAR: shadow_count = 0;
      default: res.status = ST_REJECTED;
    endcase
    res.count = 7'(shadow_count);
    return res;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_gap_pct);
  end

  // Result beats are checked before the request beat of the same edge is predicted
  always @(posedge clk_i) begin : check_and_predict
    result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $error("result beat with nothing expected: status %0d value %0d", status_o, value_o);
        end else begin
          exp_r = pending_results.pop_front();
          if (status_o !== exp_r.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
          end
          if (value_o !== exp_r.value) begin
            error_count++;
            $error("value: expected %0d, got %0d", exp_r.value, value_o);
          end
          if (position_o !== exp_r.position) begin
            error_count++;
            $error("position: expected %0d, got %0d", exp_r.position, position_o);
          end
          if (count_o !== exp_r.count) begin
            error_count++;
            $error("count: expected %0d, got %0d", exp_r.count, count_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(apply_to_key_set(operation_i, key_i, index_i));
      end
    end
  end

  // Valid stays up after the beat; the next call either replaces the payload or idles
  task automatic send_request(logic [2:0] op, logic signed [31:0] key = '0,
                              logic [6:0] idx = '0);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    operation_i = op;
    key_i       = key;
    index_i     = idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(OP_FIRST);
    send_request(OP_LAST);
    send_request(OP_NTH, '0, 7'd0);
    send_request(OP_NTH, '0, 7'd1);
    send_request(OP_SEARCH, 32'sd0);
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);           // duplicate
    send_request(OP_SEARCH, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h7FFF_FFFF);
    send_request(OP_NTH, '0, 7'd0);
    send_request(OP_NTH, '0, 7'd4);
    send_request(OP_NTH, '0, 7'd5);
    send_request(OP_NTH, -32'sd1, 7'h7F);
    send_request(OP_FIRST);
    send_request(OP_LAST);
    send_request(OP_DELETE, -32'sd1);
    send_request(OP_DELETE, 32'h7FFF_FFFF);
    send_request(OP_UNUSED, -32'sd1, 7'h7F);
    send_request(OP_SEARCH, -32'sd1);
    send_request(OP_CLEAR, 32'h5A5A_5A5A, 7'h2A);
    send_request(OP_FIRST);
  endtask

  task automatic test_fill_to_capacity();
    logic signed [31:0] fill_keys [KeyCap];
    logic signed [31:0] cand;
    logic signed [31:0] tmp;
    bit                 dup;
    int unsigned        k;
    send_request(OP_CLEAR);
    for (int unsigned i = 0; i < KeyCap; i++) begin
      do begin
        cand = $urandom;
        dup  = 1'b0;
        for (int unsigned j = 0; j < i; j++) if (fill_keys[j] == cand) dup = 1'b1;
      end while (dup);
      fill_keys[i] = cand;
      send_request(OP_INSERT, cand, 7'($urandom));
    end
    // Store is full: a duplicate is still reported as a duplicate
    send_request(OP_INSERT, fill_keys[$urandom_range(KeyCap-1, 0)]);
    send_request(OP_INSERT, ~fill_keys[0] ^ fill_keys[1]);
    send_request(OP_NTH, '0, 7'(KeyCap));
    send_request(OP_NTH, '0, 7'(KeyCap + 1));
    send_request(OP_LAST);
    send_request(OP_FIRST);
    for (int i = 0; i < 4; i++) send_request(OP_SEARCH, fill_keys[$urandom_range(KeyCap-1, 0)]);
    for (int unsigned i = KeyCap - 1; i > 0; i--) begin
      k = $urandom_range(i, 0);
      tmp = fill_keys[i];
      fill_keys[i] = fill_keys[k];
      fill_keys[k] = tmp;
    end
    for (int unsigned i = 0; i < KeyCap; i++) begin
      send_request(OP_DELETE, fill_keys[i]);
      if (i % 16 == 7) send_request(OP_LAST);
    end
    send_request(OP_LAST);
  endtask

  task automatic test_random_mix(int unsigned n_items);
    logic signed [31:0] key_pool [24];
    logic signed [31:0] key;
    logic [6:0]         idx;
    int unsigned        pick;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom;
    for (int unsigned i = 0; i < n_items; i++) begin
      key  = ($urandom_range(9, 0) < 7) ? key_pool[$urandom_range(23, 0)] : 32'($urandom);
      idx  = ($urandom_range(3, 0) == 0) ? 7'($urandom) : 7'($urandom_range(30, 0));
      pick = $urandom_range(99, 0);
      if (pick < 35)      send_request(OP_INSERT, key, idx);
      else if (pick < 55) send_request(OP_DELETE, key, idx);
      else if (pick < 72) send_request(OP_SEARCH, key, idx);
      else if (pick < 84) send_request(OP_NTH, key, idx);
      else if (pick < 90) send_request(OP_FIRST, key, idx);
      else if (pick < 96) send_request(OP_LAST, key, idx);
      else if (pick < 98) send_request(OP_CLEAR, key, idx);
      else                send_request(OP_UNUSED, key, idx);
    end
  endtask

  task automatic test_pause_until_drained();
    logic signed [31:0] key;
    key = $urandom;
    send_request(OP_INSERT, key);
    send_request(OP_INSERT, key + 32'sd1);
    send_request(OP_DELETE, key - 32'sd1);
    wait_drained();
    send_request(OP_SEARCH, key + 32'sd1);
    send_request(OP_NTH, '0, 7'd1);
    send_request(OP_DELETE, key);
    send_request(OP_LAST);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_INSERT;
    key_i        = '0;
    index_i      = '0;
    shadow_count = 0;
    error_count  = 0;
    send_gap_pct = 13;
    recv_gap_pct = 48;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fill_to_capacity();

    send_gap_pct = 48;
    recv_gap_pct = 13;
    test_random_mix(130);
    test_pause_until_drained();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_mix(130);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
